@@ src/vffd_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vffd_pkg
// Shared types and constants for the VAN frame field decoder.
// ============================================================================
package vffd_pkg;

    localparam int MAX_BYTES_DEF = 32;

    // positions inside the 10-bit symbol
    localparam logic [3:0] SYM_MANCH_LO = 4'd4;
    localparam logic [3:0] SYM_MANCH_HI = 4'd9;
    localparam logic [2:0] BIT_IDX_MSB  = 3'd7;

    typedef enum logic [1:0] {
        KIND_SOF     = 2'd0,
        KIND_IDENT   = 2'd1,
        KIND_COMMAND = 2'd2,
        KIND_DATA    = 2'd3
    } field_kind_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_BITS  = 2'd1,
        S_CMD   = 2'd2,
        S_FLUSH = 2'd3
    } seq_state_t;

    // result request from the bit unit
    typedef struct packed {
        logic        valid;
        logic        two;     // identifier now, command follows
        field_kind_t kind;
        logic [11:0] value;
    } emit_t;

endpackage

@@ src/van_frame_field_decoder.sv @@
`timescale 1ns / 1ps
// ============================================================================
// van_frame_field_decoder
// Decodes VAN line runs into start of frame, identifier, command and data.
// ============================================================================
// A run beat of n bit times (n from 1 to 7) is accepted and then deframed one
// bit per cycle by a shared bit unit while the output is not stalled, with one
// more step for the command field when the byte that completes the identifier
// also yields it. A run of 8 or more bit times is accepted and then flushes
// the partial field; an empty run is only accepted. Each field waits in a
// single output register, so a stalled master side holds the sequencer on the
// cycle that would produce a field. s_tready is high only between runs.
module van_frame_field_decoder
    import vffd_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF,
    localparam int BW = $clog2(MAX_BYTES + 1)
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // recessive_level
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // run_level[0], run_bits[8:1], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // field_kind[1:0], field_value[13:2],
                                        // data_index[18:14], zero pad
    output logic        m_tuser,        // frame_end
    output logic        m_tlast         // last_of_item
);

    seq_state_t    state_reg, state_next;
    logic          recessive_reg;
    logic          level_reg;
    logic [2:0]    rem_reg;
    logic [3:0]    cmd_reg;

    logic [3:0]    sym_cnt_reg;
    logic [BW-1:0] bytes_reg;
    logic [7:0]    shift_reg;
    logic [2:0]    bit_idx_reg;
    logic [7:0]    accum_reg;

    logic [3:0]    sym_cnt_next;
    logic [BW-1:0] bytes_next;
    logic [7:0]    shift_next;
    logic [2:0]    bit_idx_next;
    logic [7:0]    accum_next;
    logic [4:0]    data_index;
    emit_t         emit;

    logic          out_valid_reg;
    field_kind_t   out_kind_reg;
    logic [11:0]   out_value_reg;
    logic [4:0]    out_index_reg;
    logic          out_end_reg;
    logic          out_last_reg;

    logic          in_beat;
    logic          run_long;
    logic          out_free;
    logic          stall;
    logic          step_en;
    logic          flush_en;
    logic          out_load;
    field_kind_t   ld_kind;
    logic [11:0]   ld_value;
    logic [4:0]    ld_index;
    logic          ld_end;
    logic          ld_last;

    assign in_beat  = s_tvalid && s_tready;
    assign run_long = |s_tdata[8:4];
    assign out_free = !out_valid_reg || m_tready;
    assign stall    = emit.valid && !out_free;

    vffd_bit_unit #(
        .MAX_BYTES (MAX_BYTES)
    ) u_bit (
        .level        (level_reg),
        .recessive    (recessive_reg),
        .sym_cnt      (sym_cnt_reg),
        .bytes        (bytes_reg),
        .shift        (shift_reg),
        .bit_idx      (bit_idx_reg),
        .accum        (accum_reg),
        .sym_cnt_next (sym_cnt_next),
        .bytes_next   (bytes_next),
        .shift_next   (shift_next),
        .bit_idx_next (bit_idx_next),
        .accum_next   (accum_next),
        .data_index   (data_index),
        .emit         (emit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    if (run_long)
                        state_next = S_FLUSH;
                    else if (s_tdata[3:1] != 3'd0)
                        state_next = S_BITS;
                end
            end
            S_BITS:
            begin
                if (!stall)
                begin
                    if (emit.two)
                        state_next = S_CMD;
                    else if (rem_reg == 3'd1)
                        state_next = S_IDLE;
                end
            end
            S_CMD:
            begin
                if (out_free)
                    state_next = (rem_reg == 3'd0) ? S_IDLE : S_BITS;
            end
            S_FLUSH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready = 1'b0;
        step_en  = 1'b0;
        flush_en = 1'b0;
        out_load = 1'b0;
        ld_kind  = emit.kind;
        ld_value = emit.value;
        ld_index = 5'd0;
        ld_end   = 1'b0;
        ld_last  = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_BITS:
            begin
                step_en  = !stall;
                out_load = emit.valid && out_free;
                ld_last  = !emit.two;
                if (emit.kind == KIND_DATA)
                    ld_index = data_index;
            end
            S_CMD:
            begin
                out_load = out_free;
                ld_kind  = KIND_COMMAND;
                ld_value = {8'd0, cmd_reg};
            end
            S_FLUSH:
            begin
                flush_en = out_free;
                out_load = out_free;
                ld_end   = 1'b1;
                if (bytes_reg == BW'(2))
                begin
                    ld_kind  = KIND_IDENT;
                    ld_value = {accum_reg, shift_reg[7:4]};
                end
                else
                begin
                    ld_kind  = KIND_DATA;
                    ld_value = {4'd0, shift_reg};
                    ld_index = data_index;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            recessive_reg <= 1'b1;
            rem_reg       <= 3'd0;
            sym_cnt_reg   <= 4'd0;
            bytes_reg     <= '0;
            shift_reg     <= 8'd0;
            bit_idx_reg   <= BIT_IDX_MSB;
            accum_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                recessive_reg <= cfg_wdata;
            if (in_beat)
                rem_reg <= s_tdata[3:1];
            else if (step_en)
                rem_reg <= rem_reg - 3'd1;
            if (flush_en)
            begin
                sym_cnt_reg <= 4'd0;
                bytes_reg   <= '0;
                shift_reg   <= 8'd0;
                bit_idx_reg <= BIT_IDX_MSB;
                accum_reg   <= 8'd0;
            end
            else if (step_en)
            begin
                sym_cnt_reg <= sym_cnt_next;
                bytes_reg   <= bytes_next;
                shift_reg   <= shift_next;
                bit_idx_reg <= bit_idx_next;
                accum_reg   <= accum_next;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
            level_reg <= s_tdata[0];
        if (step_en && emit.two)
            cmd_reg <= shift_reg[3:0];
        if (out_load)
        begin
            out_kind_reg  <= ld_kind;
            out_value_reg <= ld_value;
            out_index_reg <= ld_index;
            out_end_reg   <= ld_end;
            out_last_reg  <= ld_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_index_reg, out_value_reg, out_kind_reg};
    assign m_tuser  = out_end_reg;
    assign m_tlast  = out_last_reg;

    a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
        sym_cnt_reg <= SYM_MANCH_HI)
        else $error("symbol bit count out of range");

    a_bytes_sat: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_reg <= BW'(MAX_BYTES))
        else $error("byte count above saturation");

    a_sym_start: assert property (@(posedge clk) disable iff (!rst_n)
        sym_cnt_reg == 4'd0 |-> bit_idx_reg == BIT_IDX_MSB && shift_reg == 8'd0)
        else $error("byte not cleared at symbol start");

    a_long_flush: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && run_long |=> state_reg == S_FLUSH)
        else $error("end of frame run did not flush");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("field loaded over a pending beat");

endmodule

@@ src/vffd_bit_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vffd_bit_unit
// One deframer step: takes a single line bit and returns the next frame
// state plus any field that the bit completes.
// ============================================================================
module vffd_bit_unit
    import vffd_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF,
    localparam int BW = $clog2(MAX_BYTES + 1)
)
(
    input  logic          level,
    input  logic          recessive,
    input  logic [3:0]    sym_cnt,
    input  logic [BW-1:0] bytes,
    input  logic [7:0]    shift,
    input  logic [2:0]    bit_idx,
    input  logic [7:0]    accum,
    output logic [3:0]    sym_cnt_next,
    output logic [BW-1:0] bytes_next,
    output logic [7:0]    shift_next,
    output logic [2:0]    bit_idx_next,
    output logic [7:0]    accum_next,
    output logic [4:0]    data_index,
    output emit_t         emit
);

    localparam int DW = (BW > 5) ? BW : 5;

    logic [DW-1:0] bytes_ext;
    logic [DW-1:0] bytes_less2;

    assign bytes_ext   = DW'(bytes);
    assign bytes_less2 = bytes_ext - DW'(2);
    assign data_index  = (bytes_ext >= DW'(2)) ? bytes_less2[4:0] : 5'd0;

    always_comb
    begin
        sym_cnt_next = sym_cnt;
        bytes_next   = bytes;
        shift_next   = shift;
        bit_idx_next = bit_idx;
        accum_next   = accum;
        emit         = '0;
        emit.kind    = KIND_SOF;
        if (sym_cnt != SYM_MANCH_LO && sym_cnt != SYM_MANCH_HI)
        begin
            if (level == recessive)
                shift_next = shift | (8'd1 << bit_idx);
            bit_idx_next = bit_idx - 3'd1;
            sym_cnt_next = sym_cnt + 4'd1;
        end
        else if (sym_cnt == SYM_MANCH_LO)
        begin
            sym_cnt_next = sym_cnt + 4'd1;
        end
        else
        begin
            // second Manchester bit closes the byte
            if (bytes == BW'(0))
            begin
                accum_next  = 8'd0;
                emit.valid  = 1'b1;
                emit.kind   = KIND_SOF;
                emit.value  = {4'd0, shift};
            end
            else if (bytes == BW'(1))
            begin
                accum_next = shift;
            end
            else if (bytes == BW'(2))
            begin
                emit.valid = 1'b1;
                emit.two   = 1'b1;
                emit.kind  = KIND_IDENT;
                emit.value = {accum, shift[7:4]};
            end
            else
            begin
                emit.valid = 1'b1;
                emit.kind  = KIND_DATA;
                emit.value = {4'd0, shift};
            end
            shift_next   = 8'd0;
            bit_idx_next = BIT_IDX_MSB;
            sym_cnt_next = 4'd0;
            if (bytes < BW'(MAX_BYTES))
                bytes_next = bytes + BW'(1);
        end
    end

endmodule
